FILE: rtl/mf3_pkg.sv
package mf3_pkg;

    // Default and fixed widths of the block.
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int PIX_W         = 8;
    localparam int ROW_W         = 12;
    localparam int IMG_W_W       = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    // Three pixels in ascending order.
    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] hi;
    } sort3_t;

    // Three compare-exchange steps order three pixels.
    function automatic sort3_t sort3(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] z;
        logic [PIX_W-1:0] t;
        sort3_t res;
        x = a;
        y = b;
        z = c;
        if (x > y)
        begin
            t = x;
            x = y;
            y = t;
        end
        if (y > z)
        begin
            t = y;
            y = z;
            z = t;
        end
        if (x > y)
        begin
            t = x;
            x = y;
            y = t;
        end
        res.lo = x;
        res.md = y;
        res.hi = z;
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        sort3_t s;
        s = sort3(a, b, c);
        return s.md;
    endfunction

endpackage

FILE: rtl/median_filter_3x3_top.sv
// 3x3 median filter for a raster stream of 8-bit grey pixels. Set image_width and
// image_height while the block is idle; a write to either restarts the frame at row 0,
// column 0 (values are saturated to 3..MAX_WIDTH and 3..4095). One pixel word is taken
// every clock unless the output stalls, and one median word leaves per interior pixel
// after stage 1, the window and the sorting network; border pixels give no word. The
// pace is set by the line store, a single memory of MAX_WIDTH entries holding the two
// rows above, read at the current column and written back as the word leaves stage 1;
// the network is three register stages deep. A stalled output holds the whole pipeline.
module median_filter_3x3_top
#(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mf3_pkg::PIX_W-1:0]         pixel_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mf3_pkg::PIX_W-1:0]         median_value,
    output logic [mf3_pkg::ROW_W-1:0]         center_row,
    output logic [COL_W-1:0]                  center_col,
    output logic                              last_in_frame
);

    import mf3_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } tag_t;

    logic [IMG_W_W-1:0]    image_width_reg;
    logic [ROW_W-1:0]      image_height_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      w_last;
    logic [ROW_W-1:0]      h_last;
    logic                  col_end;
    logic                  row_end;
    logic                  cfg_write;
    logic                  in_accept;
    logic                  adv;

    logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]    line_rd_reg;

    logic                  s1_occ_reg;
    logic                  s1_emit_reg;
    logic [PIX_W-1:0]      s1_pix_reg;
    logic [COL_W-1:0]      s1_addr_reg;
    tag_t                  s1_tag_reg;

    logic [PIX_W-1:0]      window_reg [9];
    logic                  s2_valid_reg;
    tag_t                  s2_tag_reg;

    sort3_t                s3_rows_reg [3];
    logic                  s3_valid_reg;
    tag_t                  s3_tag_reg;

    logic [PIX_W-1:0]      s4_a_reg;
    logic [PIX_W-1:0]      s4_b_reg;
    logic [PIX_W-1:0]      s4_c_reg;
    logic                  s4_valid_reg;
    tag_t                  s4_tag_reg;

    logic                  out_valid_reg;
    logic [PIX_W-1:0]      median_reg;
    tag_t                  out_tag_reg;

    // Handshakes: the pipeline moves whenever the output register is free.
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // Last column and last row after saturation of the registers.
    always_comb
    begin
        if (image_width_reg < IMG_W_W'(3))
            w_last = COL_W'(2);
        else if (int'(image_width_reg) > MAX_WIDTH)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(image_width_reg - IMG_W_W'(1));
        if (image_height_reg < ROW_W'(3))
            h_last = ROW_W'(2);
        else
            h_last = image_height_reg - ROW_W'(1);
    end

    assign col_end = (col_reg == w_last);
    assign row_end = (row_reg == h_last);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_W'(1024);
            image_height_reg <= ROW_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Raster position of the next pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Line store: the upper byte is the row two above, the lower byte the row above.
    // Read at acceptance, written back with the shifted column as the word leaves stage 1.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            line_rd_reg <= line_mem[col_reg];
        if (adv && s1_occ_reg)
            line_mem[s1_addr_reg] <= {line_rd_reg[PIX_W-1:0], s1_pix_reg};
    end

    // Stage 1: the accepted word waits for its line store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_occ_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_occ_reg  <= in_accept;
            s1_emit_reg <= in_accept && (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg      <= pixel_in;
            s1_addr_reg     <= col_reg;
            s1_tag_reg.row  <= row_reg - ROW_W'(1);
            s1_tag_reg.col  <= col_reg - COL_W'(1);
            s1_tag_reg.last <= row_end && col_end;
        end
    end

    // Stage 2: the window shifts left and takes the new right-hand column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                window_reg[k] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            for (int k = 0; k < 9; k++)
                window_reg[k] <= '0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_occ_reg && s1_emit_reg;
            if (s1_occ_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    window_reg[3*k]   <= window_reg[3*k+1];
                    window_reg[3*k+1] <= window_reg[3*k+2];
                end
                window_reg[2] <= line_rd_reg[2*PIX_W-1:PIX_W];
                window_reg[5] <= line_rd_reg[PIX_W-1:0];
                window_reg[8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_tag_reg <= s1_tag_reg;
    end

    // Stages 3 to 5: sort each row, combine the columns, take the middle one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                s3_rows_reg[k] <= sort3(window_reg[3*k], window_reg[3*k+1],
                                        window_reg[3*k+2]);
            s3_tag_reg <= s2_tag_reg;

            s4_a_reg   <= max3(s3_rows_reg[0].lo, s3_rows_reg[1].lo, s3_rows_reg[2].lo);
            s4_b_reg   <= med3(s3_rows_reg[0].md, s3_rows_reg[1].md, s3_rows_reg[2].md);
            s4_c_reg   <= min3(s3_rows_reg[0].hi, s3_rows_reg[1].hi, s3_rows_reg[2].hi);
            s4_tag_reg <= s3_tag_reg;

            median_reg  <= med3(s4_a_reg, s4_b_reg, s4_c_reg);
            out_tag_reg <= s4_tag_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign median_value  = median_reg;
    assign center_row    = out_tag_reg.row;
    assign center_col    = out_tag_reg.col;
    assign last_in_frame = out_tag_reg.last;

    // The write-back and the next read never meet at the same line store entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && adv && s1_occ_reg) |-> (col_reg != s1_addr_reg))
        else $error("line store read and write-back at the same column");

    // Every result word belongs to an interior centre pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (center_row != '0 && center_col != '0))
        else $error("result word for a border pixel");

    // A write to a size register restarts the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (col_reg == '0 && row_reg == '0))
        else $error("frame not restarted after a register write");

    // The position never runs past the last column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg_write && col_end) |=> (col_reg == '0))
        else $error("column counter did not wrap");

endmodule

FILE: tb/sv/median_filter_3x3_top_test.sv
`timescale 1ns / 100ps

module median_filter_3x3_top_test;

    import mf3_pkg::*;

    // Register indexes that map to nothing; writes to them must leave the frame alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int unsigned PIPE_DRAIN   = 12;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned REPORT_LIMIT = 10;

    // Pixel styles used when filling a frame.
    localparam int unsigned STYLE_UNIFORM = 0;
    localparam int unsigned STYLE_EXTREME = 1;
    localparam int unsigned STYLE_NARROW  = 2;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [ROW_W-1:0] row;
        logic [9:0]       col;
        logic             last;
    } median_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      median_value;
    logic [ROW_W-1:0]      center_row;
    logic [9:0]            center_col;
    logic                  last_in_frame;

    median_filter_3x3_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_value  (median_value),
        .center_row    (center_row),
        .center_col    (center_col),
        .last_in_frame (last_in_frame)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Shadow copy of the filter: line stores, window, raster position and registers.
    logic [PIX_W-1:0]   older_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]   newer_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]   window [9];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    median_word_t     pending_medians [$];
    logic [PIX_W-1:0] pixel_queue [$];

    int unsigned pixels_issued = 0;
    int unsigned pixels_accepted = 0;
    int unsigned medians_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w < 3)
            w = 3;
        if (w > DEF_MAX_WIDTH)
            w = DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h < 3)
            h = 3;
        if (h > 4095)
            h = 4095;
        return h;
    endfunction

    function automatic void restart_raster();
        for (int k = 0; k < 9; k++)
            window[k] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void reset_shadow();
        for (int k = 0; k < DEF_MAX_WIDTH; k++)
        begin
            older_row[k] = '0;
            newer_row[k] = '0;
        end
        restart_raster();
        width_reg  = 11'd1024;
        height_reg = 12'd1024;
    endfunction

    // A write to a mapped register restarts the frame; the line stores are kept.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                width_reg = data[IMG_W_W-1:0];
                restart_raster();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_reg = data[ROW_W-1:0];
                restart_raster();
            end
            default:
                ;
        endcase
    endfunction

    // Sorts a copy of the window and takes the fifth smallest pixel.
    function automatic logic [PIX_W-1:0] median_of_window();
        logic [PIX_W-1:0] v [9];
        logic [PIX_W-1:0] t;
        for (int k = 0; k < 9; k++)
            v[k] = window[k];
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8 - i; j++)
            begin
                if (v[j] > v[j + 1])
                begin
                    t = v[j];
                    v[j] = v[j + 1];
                    v[j + 1] = t;
                end
            end
        end
        return v[4];
    endfunction

    // Moves one pixel through the shadow filter and queues the median word it completes.
    function automatic void take_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        median_word_t     word;
        w = active_width();
        h = active_height();
        c = col_pos % DEF_MAX_WIDTH;
        r = row_pos;
        above2 = older_row[c];
        above1 = newer_row[c];
        for (int k = 0; k < 3; k++)
        begin
            window[3 * k]     = window[3 * k + 1];
            window[3 * k + 1] = window[3 * k + 2];
        end
        window[2] = above2;
        window[5] = above1;
        window[8] = px;
        older_row[c] = above1;
        newer_row[c] = px;
        if (r >= 2 && c >= 2)
        begin
            word.median = median_of_window();
            word.row    = ROW_W'(r - 1);
            word.col    = 10'(c - 1);
            word.last   = (r + 1 >= h) && (c + 1 >= w);
            pending_medians.push_back(word);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    // Pixel driver: offers the next queued pixel once the previous word has gone.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_in <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_pixel(pixel_in);
                pixels_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    pixel_in <= pixel_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // Median monitor: compares each word taken with the oldest prediction, and sets
    // out_ready from the stall rate or a requested long hold-off.
    always @(posedge clk)
    begin
        median_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_medians.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: median word with nothing predicted (row %0d, col %0d)",
                                 $realtime, center_row, center_col);
                end
                else
                begin
                    want = pending_medians.pop_front();
                    medians_checked++;
                    if (median_value !== want.median)
                        flag_mismatch("median_value", 32'(want.median), 32'(median_value));
                    if (center_row !== want.row)
                        flag_mismatch("center_row", 32'(want.row), 32'(center_row));
                    if (center_col !== want.col)
                        flag_mismatch("center_col", 32'(want.col), 32'(center_col));
                    if (last_in_frame !== want.last)
                        flag_mismatch("last_in_frame", 32'(want.last), 32'(last_in_frame));
                    if (want.last)
                        frames_closed++;
                end
            end
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d medians outstanding",
                         $realtime, QUIET_LIMIT, pending_medians.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        apply_register(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Registers may only change once every pixel is in and every median is out,
    // plus a drain for pixels that are still in flight without a result.
    task automatic wait_for_quiet();
        while (pixels_accepted != pixels_issued || pending_medians.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default:
            begin
                send_idle_pct  = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    task automatic offer_pixel(input logic [PIX_W-1:0] px);
        pixel_queue.push_back(px);
        pixels_issued++;
    endtask

    task automatic queue_pixels(input int unsigned count, input int unsigned style);
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] px;
        base = PIX_W'($urandom_range(252));
        for (int unsigned k = 0; k < count; k++)
        begin
            case (style)
                STYLE_EXTREME:
                begin
                    case ($urandom_range(3))
                        0: px = 8'd0;
                        1: px = 8'd255;
                        2: px = 8'd1;
                        default: px = 8'd254;
                    endcase
                end
                // Few distinct values, so ties in the sort are common.
                STYLE_NARROW:
                    px = base + PIX_W'($urandom_range(3));
                default:
                    px = PIX_W'($urandom_range(255));
            endcase
            offer_pixel(px);
        end
    endtask

    // Writes both size registers, in either order.
    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data);
        if ($urandom_range(1))
        begin
            write_register(REG_IMAGE_WIDTH, w_data);
            write_register(REG_IMAGE_HEIGHT, h_data);
        end
        else
        begin
            write_register(REG_IMAGE_HEIGHT, h_data);
            write_register(REG_IMAGE_WIDTH, w_data);
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        int unsigned           frame_px;
        int unsigned           n_px;
        int unsigned           half;
        int unsigned           phase;
        int unsigned           random_pixels;

        reset_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame: one interior pixel, five of nine at full scale.
        set_idling(0);
        set_frame(12'd3, 12'd3);
        for (int k = 0; k < 9; k++)
            offer_pixel((k % 2 == 0) ? 8'd255 : 8'd0);
        // The frame wraps; the first row of the next one gives nothing.
        offer_pixel(8'd0);
        offer_pixel(8'd128);
        offer_pixel(8'd255);
        wait_for_quiet();

        // Unmapped indexes must not restart the frame under way.
        write_register(REG_SPARE_LO, 12'hFFF);
        write_register(REG_SPARE_HI, 12'h000);
        offer_pixel(8'd255);
        offer_pixel(8'd255);
        offer_pixel(8'd0);
        offer_pixel(8'd0);
        offer_pixel(8'd0);
        offer_pixel(8'd1);
        wait_for_quiet();

        // Sizes below range saturate to three; bit 11 lies outside the width register.
        set_frame(12'h801, 12'd2);
        for (int k = 0; k < 9; k++)
            offer_pixel((k < 4) ? 8'd0 : 8'd254);
        wait_for_quiet();

        // Random small frames, mostly whole, sometimes cut short by the next write.
        phase = 0;
        random_pixels = 0;
        while (random_pixels < 280)
        begin
            w_data = CFG_DATA_W'($urandom_range(3, 12));
            case ($urandom_range(5))
                0: w_data = CFG_DATA_W'($urandom_range(2));
                1: w_data = w_data | 12'h800;
                default: ;
            endcase
            h_data = CFG_DATA_W'($urandom_range(3, 6));
            if ($urandom_range(5) == 0)
                h_data = CFG_DATA_W'($urandom_range(2));
            if ($urandom_range(3) == 0)
                write_register(REG_IMAGE_WIDTH, w_data);
            else
                set_frame(w_data, h_data);
            set_idling(phase);
            frame_px = active_width() * active_height();
            n_px = frame_px * $urandom_range(1, 2);
            if ($urandom_range(1))
                n_px += $urandom_range(frame_px - 1);
            if ($urandom_range(4) == 0)
            begin
                // Pause mid-frame for an unmapped write, then carry on.
                half = n_px / 2;
                queue_pixels(half, $urandom_range(2));
                wait_for_quiet();
                write_register($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                               CFG_DATA_W'($urandom_range(4095)));
                queue_pixels(n_px - half, $urandom_range(2));
            end
            else
            begin
                queue_pixels(n_px, $urandom_range(2));
            end
            random_pixels += n_px;
            wait_for_quiet();
            phase++;
        end

        // Tallest frame, narrow; the receiver holds off while pixels keep coming.
        set_idling(0);
        set_frame(12'd3, 12'd4095);
        queue_pixels(250, STYLE_UNIFORM);
        while (pixels_accepted + 230 < pixels_issued)
            @(posedge clk);
        hold_requests++;
        wait_for_quiet();

        repeat (2 * PIPE_DRAIN) @(posedge clk);
        $display("Run covered %0d pixels and %0d register writes; %0d medians compared.",
                 pixels_accepted, cfg_writes, medians_checked);
        $display("Frame ends flagged: %0d; frames from 3 to 12 wide and up to 4095 tall.",
                 frames_closed);
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/mf3_pkg.sv
rtl/median_filter_3x3_top.sv
tb/sv/median_filter_3x3_top_test.sv
